// ===== src/rbjd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbjd_pkg
// Shared types, codes and defaults for the ready/blocked job dispatcher.
// ----------------------------------------------------------------------------
package rbjd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FIELD_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_ADD     = 3'd1,
        OP_TICK    = 3'd2,
        OP_SWITCH  = 3'd3,
        OP_IO_DONE = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        STS_DECREMENTED   = 4'd0,
        STS_TO_BLOCKED    = 4'd1,
        STS_FINISHED      = 4'd2,
        STS_READY_TO_RUN  = 4'd3,
        STS_NO_JOBS       = 4'd4,
        STS_BLOCKED_ONLY  = 4'd5,
        STS_SWITCHED      = 4'd6,
        STS_BLOCKED_READY = 4'd7,
        STS_BLOCKED_EMPTY = 4'd8,
        STS_ADDED         = 4'd9,
        STS_CLEARED       = 4'd10,
        STS_QUEUE_FULL    = 4'd11
    } status_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_ADD,
        ACT_TICK_RUN,
        ACT_POP_READY,
        ACT_LOAD_TICK,
        ACT_LOAD_SWITCH,
        ACT_NO_READY,
        ACT_NO_BLOCKED,
        ACT_UNKNOWN,
        ACT_DRAIN_START,
        ACT_DRAIN_RD,
        ACT_DRAIN_WR
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DRAIN_RD,
        S_DRAIN_WR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] job_number;
        logic [15:0] job_cpu_time;
        logic        job_io_pending;
        logic [15:0] job_start_time;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        running_valid;
        logic [15:0] running_number;
        logic [15:0] running_cpu_time;
        logic        running_io_pending;
        logic [15:0] running_start_time;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        act_t act;
    } cmd_t;

    typedef struct packed {
        logic running_present;
        logic ready_empty;
        logic blocked_empty;
    } stat_t;

endpackage

// ===== src/rbjd_ram.sv =====
// ----------------------------------------------------------------------------
// rbjd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbjd_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rbjd_datapath.sv =====
// ----------------------------------------------------------------------------
// rbjd_datapath
// Queue pointers, running slot, status register and the two queue RAMs.
// ----------------------------------------------------------------------------
module rbjd_datapath #(
    parameter int QUEUE_DEPTH = rbjd_pkg::QUEUE_DEPTH_DEF,
    parameter int FIELD_BITS  = rbjd_pkg::FIELD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbjd_pkg::in_item_t  request,
    input  rbjd_pkg::cmd_t      cmd,
    output rbjd_pkg::stat_t     stat,
    output rbjd_pkg::out_item_t result
);

    localparam int FB  = FIELD_BITS;
    localparam int JW  = 3 * FB + 1;
    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_LSB = 2 * FB + 1;
    localparam int CPU_LSB = FB + 1;
    localparam int IO_BIT  = FB;

    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   WRAP_SUM = (CW+1)'(QUEUE_DEPTH);

    logic [FB-1:0] job_num_reg, job_cpu_reg, job_start_reg;
    logic          job_io_reg;

    logic [FB-1:0] run_num_reg, run_num_next;
    logic [FB-1:0] run_cpu_reg, run_cpu_next;
    logic [FB-1:0] run_start_reg, run_start_next;
    logic          run_io_reg, run_io_next;
    logic          present_reg, present_next;

    logic [AW-1:0] rhead_reg, rhead_next, bhead_reg, bhead_next;
    logic [CW-1:0] rcount_reg, rcount_next, bcount_reg, bcount_next;
    rbjd_pkg::status_t status_reg, status_next;

    logic [CW:0]   rsum, bsum;
    logic [AW-1:0] rtail, btail, rhead_inc, bhead_inc;
    logic          r_full, b_full;

    logic          ready_we, ready_re, blocked_we, blocked_re;
    logic [JW-1:0] ready_wdata, blocked_wdata, ready_rdata, blocked_rdata;
    logic [JW-1:0] run_job, new_job, load_job;

    assign rsum      = (CW+1)'(rhead_reg) + (CW+1)'(rcount_reg);
    assign bsum      = (CW+1)'(bhead_reg) + (CW+1)'(bcount_reg);
    assign rtail     = (rsum >= WRAP_SUM) ? AW'(rsum - WRAP_SUM) : AW'(rsum);
    assign btail     = (bsum >= WRAP_SUM) ? AW'(bsum - WRAP_SUM) : AW'(bsum);
    assign rhead_inc = (rhead_reg == LAST_IDX) ? '0 : rhead_reg + AW'(1);
    assign bhead_inc = (bhead_reg == LAST_IDX) ? '0 : bhead_reg + AW'(1);
    assign r_full    = (rcount_reg == FULL_CNT);
    assign b_full    = (bcount_reg == FULL_CNT);

    assign run_job  = {run_num_reg, run_cpu_reg, run_io_reg, run_start_reg};
    assign new_job  = {job_num_reg, job_cpu_reg, job_io_reg, job_start_reg};
    assign load_job = ready_rdata;

    assign blocked_wdata = {run_num_reg, run_cpu_reg, 1'b0, run_start_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            job_num_reg   <= FB'(request.job_number);
            job_cpu_reg   <= FB'(request.job_cpu_time);
            job_io_reg    <= request.job_io_pending;
            job_start_reg <= FB'(request.job_start_time);
        end
    end

    always_comb
    begin
        run_num_next   = run_num_reg;
        run_cpu_next   = run_cpu_reg;
        run_io_next    = run_io_reg;
        run_start_next = run_start_reg;
        present_next   = present_reg;
        rhead_next     = rhead_reg;
        rcount_next    = rcount_reg;
        bhead_next     = bhead_reg;
        bcount_next    = bcount_reg;
        status_next    = status_reg;
        ready_we       = 1'b0;
        ready_re       = 1'b0;
        ready_wdata    = new_job;
        blocked_we     = 1'b0;
        blocked_re     = 1'b0;

        case (cmd.act)
            rbjd_pkg::ACT_CLEAR:
            begin
                rhead_next     = '0;
                rcount_next    = '0;
                bhead_next     = '0;
                bcount_next    = '0;
                run_num_next   = '0;
                run_cpu_next   = '0;
                run_io_next    = 1'b0;
                run_start_next = '0;
                present_next   = 1'b0;
                status_next    = rbjd_pkg::STS_CLEARED;
            end
            rbjd_pkg::ACT_ADD:
            begin
                if (r_full)
                begin
                    status_next = rbjd_pkg::STS_QUEUE_FULL;
                end
                else
                begin
                    ready_we    = 1'b1;
                    rcount_next = rcount_reg + CW'(1);
                    status_next = rbjd_pkg::STS_ADDED;
                end
            end
            rbjd_pkg::ACT_TICK_RUN:
            begin
                if (run_cpu_reg != '0)
                begin
                    run_cpu_next = run_cpu_reg - FB'(1);
                    status_next  = rbjd_pkg::STS_DECREMENTED;
                end
                else
                begin
                    if (run_io_reg)
                    begin
                        if (b_full)
                        begin
                            status_next = rbjd_pkg::STS_QUEUE_FULL;
                        end
                        else
                        begin
                            blocked_we  = 1'b1;
                            bcount_next = bcount_reg + CW'(1);
                            status_next = rbjd_pkg::STS_TO_BLOCKED;
                        end
                    end
                    else
                    begin
                        status_next = rbjd_pkg::STS_FINISHED;
                    end
                    run_num_next   = '0;
                    run_cpu_next   = '0;
                    run_io_next    = 1'b0;
                    run_start_next = '0;
                    present_next   = 1'b0;
                end
            end
            rbjd_pkg::ACT_POP_READY:
            begin
                ready_re    = 1'b1;
                rhead_next  = rhead_inc;
                rcount_next = rcount_reg - CW'(1);
            end
            rbjd_pkg::ACT_LOAD_TICK:
            begin
                run_num_next   = load_job[NUM_LSB +: FB];
                run_cpu_next   = (load_job[CPU_LSB +: FB] != '0) ?
                                 load_job[CPU_LSB +: FB] - FB'(1) : '0;
                run_io_next    = load_job[IO_BIT];
                run_start_next = load_job[FB-1:0];
                present_next   = 1'b1;
                status_next    = rbjd_pkg::STS_READY_TO_RUN;
            end
            rbjd_pkg::ACT_LOAD_SWITCH:
            begin
                // a finished job with io pending is dropped, not requeued
                if (present_reg && !(run_cpu_reg == '0 && run_io_reg))
                begin
                    ready_we    = 1'b1;
                    ready_wdata = run_job;
                    rcount_next = rcount_reg + CW'(1);
                end
                run_num_next   = load_job[NUM_LSB +: FB];
                run_cpu_next   = load_job[CPU_LSB +: FB];
                run_io_next    = load_job[IO_BIT];
                run_start_next = load_job[FB-1:0];
                present_next   = 1'b1;
                status_next    = rbjd_pkg::STS_SWITCHED;
            end
            rbjd_pkg::ACT_NO_READY:
            begin
                status_next = (bcount_reg != '0) ? rbjd_pkg::STS_BLOCKED_ONLY :
                                                   rbjd_pkg::STS_NO_JOBS;
            end
            rbjd_pkg::ACT_NO_BLOCKED:
            begin
                status_next = rbjd_pkg::STS_BLOCKED_EMPTY;
            end
            rbjd_pkg::ACT_UNKNOWN:
            begin
                status_next = rbjd_pkg::STS_NO_JOBS;
            end
            rbjd_pkg::ACT_DRAIN_START:
            begin
                blocked_re  = 1'b1;
                bhead_next  = bhead_inc;
                bcount_next = bcount_reg - CW'(1);
                status_next = rbjd_pkg::STS_BLOCKED_READY;
            end
            rbjd_pkg::ACT_DRAIN_RD:
            begin
                blocked_re  = 1'b1;
                bhead_next  = bhead_inc;
                bcount_next = bcount_reg - CW'(1);
            end
            rbjd_pkg::ACT_DRAIN_WR:
            begin
                if (r_full)
                begin
                    status_next = rbjd_pkg::STS_QUEUE_FULL;
                end
                else
                begin
                    ready_we    = 1'b1;
                    ready_wdata = blocked_rdata;
                    rcount_next = rcount_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_num_reg   <= '0;
            run_cpu_reg   <= '0;
            run_io_reg    <= 1'b0;
            run_start_reg <= '0;
            present_reg   <= 1'b0;
            rhead_reg     <= '0;
            rcount_reg    <= '0;
            bhead_reg     <= '0;
            bcount_reg    <= '0;
            status_reg    <= rbjd_pkg::STS_NO_JOBS;
        end
        else
        begin
            run_num_reg   <= run_num_next;
            run_cpu_reg   <= run_cpu_next;
            run_io_reg    <= run_io_next;
            run_start_reg <= run_start_next;
            present_reg   <= present_next;
            rhead_reg     <= rhead_next;
            rcount_reg    <= rcount_next;
            bhead_reg     <= bhead_next;
            bcount_reg    <= bcount_next;
            status_reg    <= status_next;
        end
    end

    rbjd_ram #(
        .WIDTH(JW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ready_ram (
        .clk  (clk),
        .we   (ready_we),
        .waddr(rtail),
        .wdata(ready_wdata),
        .re   (ready_re),
        .raddr(rhead_reg),
        .rdata(ready_rdata)
    );

    rbjd_ram #(
        .WIDTH(JW),
        .DEPTH(QUEUE_DEPTH)
    ) u_blocked_ram (
        .clk  (clk),
        .we   (blocked_we),
        .waddr(btail),
        .wdata(blocked_wdata),
        .re   (blocked_re),
        .raddr(bhead_reg),
        .rdata(blocked_rdata)
    );

    assign stat.running_present = present_reg;
    assign stat.ready_empty     = (rcount_reg == '0);
    assign stat.blocked_empty   = (bcount_reg == '0);

    assign result.status             = status_reg;
    assign result.running_valid      = present_reg;
    assign result.running_number     = present_reg ? 16'(run_num_reg) : 16'd0;
    assign result.running_cpu_time   = present_reg ? 16'(run_cpu_reg) : 16'd0;
    assign result.running_io_pending = present_reg & run_io_reg;
    assign result.running_start_time = present_reg ? 16'(run_start_reg) : 16'd0;

    a_ready_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= FULL_CNT)
        else $error("ready count above depth");

    a_blocked_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= FULL_CNT)
        else $error("blocked count above depth");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !present_reg |-> (run_num_reg == '0 && run_cpu_reg == '0 &&
                          !run_io_reg && run_start_reg == '0))
        else $error("empty running slot holds data");

endmodule

// ===== src/rbjd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbjd_ctrl
// Sequencer for the dispatcher: decodes the op and steps the datapath.
// ----------------------------------------------------------------------------
module rbjd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2:0]      op,
    input  rbjd_pkg::stat_t stat,
    output rbjd_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    rbjd_pkg::state_t state_reg, state_next;
    logic [2:0]       op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbjd_pkg::S_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.load_item = 1'b0;
        cmd.act       = rbjd_pkg::ACT_NONE;
        busy          = (state_reg != rbjd_pkg::S_IDLE);
        done          = (state_reg == rbjd_pkg::S_FIN);

        case (state_reg)
            rbjd_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next       = op;
                    cmd.load_item = 1'b1;
                    state_next    = rbjd_pkg::S_EXEC;
                end
            end
            rbjd_pkg::S_EXEC:
            begin
                state_next = rbjd_pkg::S_FIN;
                case (op_reg)
                    rbjd_pkg::OP_CLEAR:
                    begin
                        cmd.act = rbjd_pkg::ACT_CLEAR;
                    end
                    rbjd_pkg::OP_ADD:
                    begin
                        cmd.act = rbjd_pkg::ACT_ADD;
                    end
                    rbjd_pkg::OP_TICK:
                    begin
                        if (stat.running_present)
                        begin
                            cmd.act = rbjd_pkg::ACT_TICK_RUN;
                        end
                        else if (!stat.ready_empty)
                        begin
                            cmd.act    = rbjd_pkg::ACT_POP_READY;
                            state_next = rbjd_pkg::S_LOAD;
                        end
                        else
                        begin
                            cmd.act = rbjd_pkg::ACT_NO_READY;
                        end
                    end
                    rbjd_pkg::OP_SWITCH:
                    begin
                        if (!stat.ready_empty)
                        begin
                            cmd.act    = rbjd_pkg::ACT_POP_READY;
                            state_next = rbjd_pkg::S_LOAD;
                        end
                        else
                        begin
                            cmd.act = rbjd_pkg::ACT_NO_READY;
                        end
                    end
                    rbjd_pkg::OP_IO_DONE:
                    begin
                        if (!stat.blocked_empty)
                        begin
                            cmd.act    = rbjd_pkg::ACT_DRAIN_START;
                            state_next = rbjd_pkg::S_DRAIN_WR;
                        end
                        else
                        begin
                            cmd.act = rbjd_pkg::ACT_NO_BLOCKED;
                        end
                    end
                    default:
                    begin
                        cmd.act = rbjd_pkg::ACT_UNKNOWN;
                    end
                endcase
            end
            rbjd_pkg::S_LOAD:
            begin
                cmd.act    = (op_reg == rbjd_pkg::OP_TICK) ? rbjd_pkg::ACT_LOAD_TICK :
                                                             rbjd_pkg::ACT_LOAD_SWITCH;
                state_next = rbjd_pkg::S_FIN;
            end
            rbjd_pkg::S_DRAIN_RD:
            begin
                cmd.act    = rbjd_pkg::ACT_DRAIN_RD;
                state_next = rbjd_pkg::S_DRAIN_WR;
            end
            rbjd_pkg::S_DRAIN_WR:
            begin
                cmd.act    = rbjd_pkg::ACT_DRAIN_WR;
                state_next = stat.blocked_empty ? rbjd_pkg::S_FIN : rbjd_pkg::S_DRAIN_RD;
            end
            rbjd_pkg::S_FIN:
            begin
                state_next = rbjd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rbjd_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == rbjd_pkg::S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbjd_pkg::S_LOAD) |-> ($past(state_reg) == rbjd_pkg::S_EXEC))
        else $error("load step without a preceding pop");

endmodule

// ===== src/ready_blocked_job_dispatcher.sv =====
// ----------------------------------------------------------------------------
// ready_blocked_job_dispatcher
// Round-robin job dispatcher with ready and blocked queues and one running slot.
// ----------------------------------------------------------------------------
// Steps: accept, execute, finish; a tick or switch that pops the ready queue adds
// a load step (registered RAM read); io complete drains the blocked queue with
// one RAM read and one RAM write per job before finishing.
// A new transaction is accepted only while busy is low, after the previous done.
// Results cannot be stalled; done is high for exactly one cycle per transaction.
// Reset clears pointers, counts and the running slot at once; queue RAMs need no clearing.
// ----------------------------------------------------------------------------
module ready_blocked_job_dispatcher #(
    parameter int QUEUE_DEPTH = rbjd_pkg::QUEUE_DEPTH_DEF,
    parameter int FIELD_BITS  = rbjd_pkg::FIELD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rbjd_pkg::in_item_t  request,
    output logic                done,
    output rbjd_pkg::out_item_t result
);

    rbjd_pkg::cmd_t  cmd;
    rbjd_pkg::stat_t stat;

    rbjd_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .op   (request.op),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    rbjd_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .FIELD_BITS (FIELD_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
